>>> sv/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, base codes and genetic code lookup for the template
// translator.
// ----------------------------------------------------------------------------
package dtp_pkg;

   // mRNA base codes
   typedef logic [2:0] base_code_type;

   localparam base_code_type CODE_U = 3'd0;
   localparam base_code_type CODE_C = 3'd1;
   localparam base_code_type CODE_A = 3'd2;
   localparam base_code_type CODE_G = 3'd3;
   localparam base_code_type CODE_N = 3'd4;

   typedef logic [7:0] ascii_type;
   typedef logic [1:0] fill_type;

   localparam fill_type FILL_FULL = 2'd2;

   localparam ascii_type CHAR_X    = "X";
   localparam ascii_type CHAR_NONE = 8'h00;

   // result transaction
   typedef struct packed {
      ascii_type rna_base;
      logic      amino_valid;
      ascii_type amino_letter;
      logic      seq_last;
   } rsp_type;

   // standard genetic code, index = {first, second, third} with U C A G order
   localparam ascii_type AMINO_TABLE [64] = '{
      "F", "F", "L", "L", "S", "S", "S", "S",
      "Y", "Y", "*", "*", "C", "C", "*", "W",
      "L", "L", "L", "L", "P", "P", "P", "P",
      "H", "H", "Q", "Q", "R", "R", "R", "R",
      "I", "I", "I", "M", "T", "T", "T", "T",
      "N", "N", "K", "K", "S", "S", "R", "R",
      "V", "V", "V", "V", "A", "A", "A", "A",
      "D", "D", "E", "E", "G", "G", "G", "G"
   };

   // template base to complementary mRNA code
   function automatic base_code_type complement_code(ascii_type dna);
      base_code_type code;
      case (dna)
         "G":     code = CODE_C;
         "C":     code = CODE_G;
         "A":     code = CODE_U;
         "T":     code = CODE_A;
         default: code = CODE_N;
      endcase
      return code;
   endfunction

   // mRNA code to its ASCII letter
   function automatic ascii_type code_letter(base_code_type code);
      ascii_type letter;
      case (code)
         CODE_U:  letter = "U";
         CODE_C:  letter = "C";
         CODE_A:  letter = "A";
         CODE_G:  letter = "G";
         default: letter = "N";
      endcase
      return letter;
   endfunction

   // codon to amino acid letter, any unknown base gives X
   function automatic ascii_type lookup_amino(base_code_type a, base_code_type b,
                                              base_code_type c);
      ascii_type letter;
      if (a[2] || b[2] || c[2]) begin
         letter = CHAR_X;
      end else begin
         letter = AMINO_TABLE[{a[1:0], b[1:0], c[1:0]}];
      end
      return letter;
   endfunction

endpackage

>>> sv/dtp_codon_unit.sv
// ----------------------------------------------------------------------------
// dtp_codon_unit
// Codon buffer and translation logic; holds up to two earlier bases and
// forms the result for the base in the input register.
// ----------------------------------------------------------------------------
module dtp_codon_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  dtp_pkg::ascii_type      dna_base,
   input  logic                    seq_end,
   output dtp_pkg::rsp_type        result
);
   import dtp_pkg::*;

   base_code_type held0_ff, held0_in;
   base_code_type held1_ff, held1_in;
   fill_type      fill_ff, fill_in;
   base_code_type code;

   // translate current base and update codon buffer
   always_comb begin
      code     = complement_code(dna_base);
      held0_in = held0_ff;
      held1_in = held1_ff;
      fill_in  = fill_ff;
      result.rna_base     = code_letter(code);
      result.seq_last     = seq_end;
      result.amino_valid  = 1'b0;
      result.amino_letter = CHAR_NONE;
      if (fill_ff == FILL_FULL) begin
         result.amino_valid  = 1'b1;
         result.amino_letter = lookup_amino(held0_ff, held1_ff, code);
         fill_in             = '0;
      end else if (seq_end) begin
         result.amino_valid  = 1'b1;
         result.amino_letter = CHAR_X;
         fill_in             = '0;
      end else begin
         if (fill_ff[0]) begin
            held1_in = code;
         end else begin
            held0_in = code;
         end
         fill_in = fill_ff + 2'd1;
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (advance) begin
         fill_ff <= fill_in;
      end
   end

   // held bases, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
   end

   // fill never passes two bases
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("codon fill count out of range");

   // a complete codon empties the buffer
   a_full_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && fill_ff == FILL_FULL) |=> fill_ff == 2'd0)
      else $error("codon buffer not cleared after full codon");

   // an amino acid only on a third base or at the end of a sequence
   a_amino_cause: assert property (@(posedge clock) disable iff (reset)
      result.amino_valid |-> (fill_ff == FILL_FULL || seq_end))
      else $error("amino acid without codon or sequence end");

   // the end of a sequence always leaves the buffer empty
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && seq_end) |=> fill_ff == 2'd0)
      else $error("codon buffer not cleared at sequence end");

endmodule

>>> sv/dna_template_to_protein_translator.sv
// ----------------------------------------------------------------------------
// dna_template_to_protein_translator
// Complements DNA template bases to mRNA and translates every codon with
// the standard genetic code.
// ----------------------------------------------------------------------------
// rsp_valid rises after the req transaction has passed the input and result regs
// throughput: one transaction per cycle unless the result side stalls, set by the
// combinational codon logic between the input register and the result register
// reset: synchronous, clears both valid flags and the codon fill count;
// the block is ready as soon as reset is released
module dna_template_to_protein_translator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dtp_pkg::ascii_type      req_dna_base,
   input  logic                    req_seq_end,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dtp_pkg::ascii_type      rsp_rna_base,
   output logic                    rsp_amino_valid,
   output dtp_pkg::ascii_type      rsp_amino_letter,
   output logic                    rsp_seq_last
);
   import dtp_pkg::*;

   logic      in_valid_ff;
   ascii_type in_base_ff;
   logic      in_end_ff;
   logic      out_valid_ff;
   rsp_type   out_data_ff;
   rsp_type   result;
   logic      out_free;
   logic      advance;

   // handshake between stages
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_base_ff <= req_dna_base;
         in_end_ff  <= req_seq_end;
      end
   end

   dtp_codon_unit u_codon (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .dna_base (in_base_ff),
      .seq_end  (in_end_ff),
      .result   (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_rna_base     = out_data_ff.rna_base;
   assign rsp_amino_valid  = out_data_ff.amino_valid;
   assign rsp_amino_letter = out_data_ff.amino_letter;
   assign rsp_seq_last     = out_data_ff.seq_last;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the template translator: a directed table of
// bases followed by random sequences, with bursty input and a stalling
// result side, every result compared against its table entry or a codon predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import dtp_pkg::*;

   // one row of directed stimulus, want is used only when typed is set
   typedef struct packed {
      ascii_type dna;
      logic      last;
      logic      typed;
      rsp_type   want;
   } stim_row_type;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_mode_type;

   localparam int RANDOM_ITEMS   = 830;
   localparam int DRAIN_POINT    = 400;
   localparam int SETTLE_CYCLES  = 8;

   // standard genetic code, first character at index 0, U C A G order
   localparam logic [8*64-1:0] GENETIC_CODE =
      "FFLLSSSSYY**CC*WLLLLPPPPHHQQRRRRIIIMTTTTNNKKSSRRVVVVAAAADDEEGGGG";

   localparam stim_row_type DIRECTED_ROWS [24] = '{
      // single base then end: partial codon
      '{"G",   1'b1, 1'b1, '{"C", 1'b1, CHAR_X,    1'b1}},
      // start codon
      '{"T",   1'b0, 1'b1, '{"A", 1'b0, CHAR_NONE, 1'b0}},
      '{"A",   1'b0, 1'b1, '{"U", 1'b0, CHAR_NONE, 1'b0}},
      '{"C",   1'b0, 1'b1, '{"G", 1'b1, "M",       1'b0}},
      // stop codon
      '{"A",   1'b0, 1'b1, '{"U", 1'b0, CHAR_NONE, 1'b0}},
      '{"T",   1'b0, 1'b1, '{"A", 1'b0, CHAR_NONE, 1'b0}},
      '{"T",   1'b0, 1'b1, '{"A", 1'b1, "*",       1'b0}},
      // byte extremes and lower case give unknown bases
      '{8'h00, 1'b0, 1'b1, '{"N", 1'b0, CHAR_NONE, 1'b0}},
      '{8'hFF, 1'b0, 1'b1, '{"N", 1'b0, CHAR_NONE, 1'b0}},
      '{"g",   1'b0, 1'b1, '{"N", 1'b1, CHAR_X,    1'b0}},
      // two bases then end: partial codon
      '{"A",   1'b0, 1'b1, '{"U", 1'b0, CHAR_NONE, 1'b0}},
      '{"C",   1'b1, 1'b1, '{"G", 1'b1, CHAR_X,    1'b1}},
      // full codon ending on the last base
      '{"C",   1'b0, 1'b1, '{"G", 1'b0, CHAR_NONE, 1'b0}},
      '{"C",   1'b0, 1'b1, '{"G", 1'b0, CHAR_NONE, 1'b0}},
      '{"C",   1'b1, 1'b1, '{"G", 1'b1, "G",       1'b1}},
      // ordinary codons
      '{"T",   1'b0, 1'b0, '0},
      '{"C",   1'b0, 1'b0, '0},
      '{"A",   1'b0, 1'b0, '0},
      '{"A",   1'b0, 1'b0, '0},
      '{"C",   1'b0, 1'b0, '0},
      '{"G",   1'b0, 1'b0, '0},
      // unknown bases in a codon that closes the sequence
      '{"t",   1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      '{8'hAA, 1'b1, 1'b0, '0}
   };

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   ascii_type req_dna_base;
   logic      req_seq_end;
   logic      rsp_valid;
   logic      rsp_ready;
   ascii_type rsp_rna_base;
   logic      rsp_amino_valid;
   ascii_type rsp_amino_letter;
   logic      rsp_seq_last;

   // predictor state
   base_code_type codon_codes [2];
   fill_type      codon_count;

   rsp_type expected_translations [$];
   int      mismatch_count;
   int      burst_left;

   dna_template_to_protein_translator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_dna_base     (req_dna_base),
      .req_seq_end      (req_seq_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rna_base     (rsp_rna_base),
      .rsp_amino_valid  (rsp_amino_valid),
      .rsp_amino_letter (rsp_amino_letter),
      .rsp_seq_last     (rsp_seq_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // complement one base and advance the codon, giving the expected result
   function automatic rsp_type translate_base(ascii_type dna, logic last);
      rsp_type       r;
      base_code_type code;
      int            idx;
      case (dna)
         "G":     code = CODE_C;
         "C":     code = CODE_G;
         "A":     code = CODE_U;
         "T":     code = CODE_A;
         default: code = CODE_N;
      endcase
      case (code)
         CODE_U:  r.rna_base = "U";
         CODE_C:  r.rna_base = "C";
         CODE_A:  r.rna_base = "A";
         CODE_G:  r.rna_base = "G";
         default: r.rna_base = "N";
      endcase
      r.seq_last     = last;
      r.amino_valid  = 1'b0;
      r.amino_letter = CHAR_NONE;
      if (codon_count == FILL_FULL) begin
         // third base closes the codon
         r.amino_valid = 1'b1;
         if (codon_codes[0] >= CODE_N || codon_codes[1] >= CODE_N || code >= CODE_N) begin
            r.amino_letter = CHAR_X;
         end else begin
            idx = int'({codon_codes[0][1:0], codon_codes[1][1:0], code[1:0]});
            r.amino_letter = GENETIC_CODE[8*(63-idx) +: 8];
         end
         codon_count = '0;
      end else if (last) begin
         // sequence ends inside a codon
         r.amino_valid  = 1'b1;
         r.amino_letter = CHAR_X;
         codon_count    = '0;
      end else begin
         codon_codes[codon_count[0]] = code;
         codon_count = codon_count + 1'b1;
      end
      return r;
   endfunction

   // present one base, wait for the transaction, record what must come back
   task automatic send_base(input ascii_type dna, input logic last, input logic typed,
                            input rsp_type want);
      rsp_type predicted;
      rsp_type queued;
      req_valid    <= 1'b1;
      req_dna_base <= dna;
      req_seq_end  <= last;
      do @(posedge clock); while (!req_ready);
      predicted = translate_base(dna, last);
      queued    = typed ? want : predicted;
      expected_translations = {expected_translations, queued};
      @(negedge clock);
   endtask

   // bursts of random length with random gaps, or a full drain when asked
   task automatic pace_sender(input logic drain);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         if ($urandom_range(9) >= 3) gap = $urandom_range(6, 1);
      end else begin
         burst_left--;
      end
      if (drain || gap > 0) begin
         req_valid    <= 1'b0;
         req_dna_base <= ascii_type'($urandom_range(255));
         req_seq_end  <= 1'($urandom_range(1));
         repeat (gap) @(negedge clock);
         if (drain) begin
            do @(negedge clock); while (expected_translations.size() != 0);
         end
      end
   endtask

   // result side stalls on stretches of its own
   initial begin
      ready_mode_type mode;
      int             run;
      rsp_ready = 1'b0;
      forever begin
         mode = ready_mode_type'($urandom_range(2));
         run  = $urandom_range(40, 5);
         repeat (run) begin
            @(negedge clock);
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF:   rsp_ready <= 1'($urandom_range(1));
               default:      rsp_ready <= ($urandom_range(3) == 0);
            endcase
         end
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_rna_base, rsp_amino_valid, rsp_amino_letter, rsp_seq_last};
         if (expected_translations.size() == 0) begin
            $display("%0t: unexpected result, expected none got %h", $time, got);
            mismatch_count++;
         end else begin
            want = expected_translations.pop_front();
            if (got.rna_base !== want.rna_base) begin
               $display("%0t: rna_base expected %h got %h", $time, want.rna_base,
                        got.rna_base);
               mismatch_count++;
            end
            if (got.amino_valid !== want.amino_valid) begin
               $display("%0t: amino_valid expected %b got %b", $time, want.amino_valid,
                        got.amino_valid);
               mismatch_count++;
            end
            if (got.amino_letter !== want.amino_letter) begin
               $display("%0t: amino_letter expected %h got %h", $time, want.amino_letter,
                        got.amino_letter);
               mismatch_count++;
            end
            if (got.seq_last !== want.seq_last) begin
               $display("%0t: seq_last expected %b got %b", $time, want.seq_last,
                        got.seq_last);
               mismatch_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      ascii_type dna;
      logic      last;
      int        pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_dna_base   = '0;
      req_seq_end    = 1'b0;
      codon_count    = '0;
      codon_codes[0] = CODE_N;
      codon_codes[1] = CODE_N;
      mismatch_count = 0;
      burst_left     = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[i]) begin
         send_base(DIRECTED_ROWS[i].dna, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);
         pace_sender(1'b0);
      end

      // random sequences, mostly valid template bases
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            case ($urandom_range(3))
               0:       dna = "G";
               1:       dna = "C";
               2:       dna = "A";
               default: dna = "T";
            endcase
         end else begin
            dna = ascii_type'($urandom_range(255));
         end
         last = ($urandom_range(11) == 0);
         send_base(dna, last, 1'b0, '0);
         pace_sender(i == DRAIN_POINT);
      end
      req_valid <= 1'b0;

      // let the pipeline empty
      while (expected_translations.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
